// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files that carry checks
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen, off while reset is held
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/ble_pkg.sv
// types and constants of the bounded list engine
// no dependencies; used by ble_mem, ble_ctrl and bounded_list_engine
package ble_pkg;

    // operation codes of the command port
    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_DEL_HEAD = 3'd2,
        OP_DEL_TAIL = 3'd3,
        OP_FIND     = 3'd4,
        OP_DEL_VAL  = 3'd5,
        OP_READ_AT  = 3'd6,
        OP_CLEAR    = 3'd7
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SCAN  = 5'b01000,
        S_SHIFT = 5'b10000
    } t_state;

    // widest key store address the engine supports
    localparam int MEM_AW_MAX = 12;

    // one key store access request: write port and read address
    typedef struct packed {
        logic                  we;
        logic [MEM_AW_MAX-1:0] waddr;
        logic [31:0]           wdata;
        logic [MEM_AW_MAX-1:0] raddr;
    } t_mem_req;

endpackage

// File: rtl/core/bounded_list_engine.sv
// bounded list engine top level: controller plus key store
// depends on ble_pkg, ble_ctrl, ble_mem and assert_macros.svh
//
//  channel   | handshake      | signals
//  ----------+----------------+---------------------------------------------
//  command   | start / busy   | i_operation, i_value_in, i_position
//  result    | o_done strobe  | o_status, o_value_out, o_position_out
//
// a transfer of a command takes place at an edge with start high and busy low
// inserts and clear finish in S_EXEC; end deletes and read-at then pass S_FETCH, unless nothing to read
// find and delete-by-value walk the list in S_SCAN with one key store read per
// cycle during the search, then one read and one write per cycle to close the gap
// synchronous active-low reset empties the list; key store contents are not cleared
// the result strobe lasts one cycle and cannot be held off; busy falls with it
`include "assert_macros.svh"

module bounded_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value_in,
    input  logic [5:0]         i_position,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [5:0]         o_position_out
);
    import ble_pkg::*;

    t_mem_req    mem_req;
    logic [31:0] mem_rdata;

    // sequencer and list pointers
    ble_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_value_in     (i_value_in),
        .i_position     (i_position),
        .o_mem_req      (mem_req),
        .i_mem_rdata    (mem_rdata),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_value_out    (o_value_out),
        .o_position_out (o_position_out)
    );

    // key store
    ble_mem #(
        .DEPTH(CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // checks
    `ASSERT_CLKED(a_accept_busy, i_clk, i_rst_n,
        (start && !busy) |=> busy, "no busy after command transfer")
    `ASSERT_CLKED(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result strobe while busy")
    `ASSERT_CLKED(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "result strobe repeated")
    `ASSERT_CLKED(a_full_payload, i_clk, i_rst_n,
        (o_done && o_status == ST_FULL) |-> (o_value_out == 0 && o_position_out == 0),
        "dropped insert carries payload")
    `ASSERT_NEVER(a_status_code, i_clk, i_rst_n,
        o_done && o_status != ST_OK && o_status != ST_MISS && o_status != ST_FULL,
        "undefined status code")

endmodule

// File: rtl/core/ble_mem.sv
// key store: one write port, one read port, registered read data
// depends on ble_pkg (t_mem_req)
module ble_mem #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  ble_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    import ble_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_req.raddr[AW-1:0]];
    end

endmodule

// File: rtl/core/ble_ctrl.sv
// list controller: ring pointers, operation sequencer and result registers
// depends on ble_pkg; drives the key store in ble_mem
module ble_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value_in,
    input  logic [5:0]         i_position,
    output ble_pkg::t_mem_req  o_mem_req,
    input  logic [31:0]        i_mem_rdata,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [5:0]         o_position_out
);
    import ble_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PCW = (CW > 6) ? CW : 6;
    localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [31:0]        r_key, n_key;
    logic [5:0]         r_pos, n_pos;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_slot, n_slot;
    logic               r_done, n_done;
    logic [1:0]         r_status, n_status;
    logic [31:0]        r_value, n_value;
    logic [5:0]         r_pos_out, n_pos_out;

    logic               full, empty, pos_ok, hit, last_idx, more;
    logic [AW-1:0]      head_dec, tail_slot, back_slot, pos_slot, slot_n1, slot_n2;
    logic [CW-1:0]      idx_next;

    // slot arithmetic modulo the capacity, both operands below it
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_W) begin
            s = s - CAP_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    // list geometry
    assign full      = (r_count == CAP_C);
    assign empty     = (r_count == '0);
    assign head_dec  = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
    assign tail_slot = ring_add(r_head, AW'(r_count));
    assign back_slot = ring_add(r_head, AW'(r_count - 1'b1));
    assign pos_slot  = ring_add(r_head, AW'(r_pos));
    assign pos_ok    = (PCW'(r_pos) < PCW'(r_count));

    // walk pointers for search and gap closing
    assign slot_n1   = ring_inc(r_slot);
    assign slot_n2   = ring_inc(slot_n1);
    assign idx_next  = CW'(r_idx) + CW'(1);
    assign last_idx  = (idx_next == r_count);
    assign more      = (idx_next < r_count);
    assign hit       = (i_mem_rdata == r_key);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_pos     = r_pos;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_done    = 1'b0;
        n_status  = r_status;
        n_value   = r_value;
        n_pos_out = r_pos_out;
        o_mem_req = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_key   = i_value_in;
                    n_pos   = i_position;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status  = ST_OK;
                n_value   = '0;
                n_pos_out = '0;
                case (r_op)
                    OP_INS_HEAD: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = MEM_AW_MAX'(head_dec);
                            o_mem_req.wdata = r_key;
                            n_head          = head_dec;
                            n_count         = r_count + 1'b1;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_INS_TAIL: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = MEM_AW_MAX'(tail_slot);
                            o_mem_req.wdata = r_key;
                            n_count         = r_count + 1'b1;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_DEL_HEAD: begin
                        if (empty) begin
                            n_status = ST_MISS;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_mem_req.raddr = MEM_AW_MAX'(r_head);
                            n_head          = ring_inc(r_head);
                            n_count         = r_count - 1'b1;
                            n_state         = S_FETCH;
                        end
                    end
                    OP_DEL_TAIL: begin
                        if (empty) begin
                            n_status = ST_MISS;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_mem_req.raddr = MEM_AW_MAX'(back_slot);
                            n_count         = r_count - 1'b1;
                            n_state         = S_FETCH;
                        end
                    end
                    OP_READ_AT: begin
                        if (pos_ok) begin
                            o_mem_req.raddr = MEM_AW_MAX'(pos_slot);
                            n_state         = S_FETCH;
                        end else begin
                            n_status = ST_MISS;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    OP_FIND, OP_DEL_VAL: begin
                        if (empty) begin
                            n_status = ST_MISS;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_mem_req.raddr = MEM_AW_MAX'(r_head);
                            n_slot          = r_head;
                            n_idx           = '0;
                            n_state         = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        n_head  = '0;
                        n_count = '0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            // read data of the single access is back
            S_FETCH: begin
                n_value = i_mem_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            // compare entry at r_idx while the next one is read
            S_SCAN: begin
                o_mem_req.raddr = MEM_AW_MAX'(slot_n1);
                if (hit) begin
                    if (r_op == OP_FIND) begin
                        n_pos_out = 6'(r_idx);
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_value = i_mem_rdata;
                        n_state = S_SHIFT;
                    end
                end else if (last_idx) begin
                    n_status = ST_MISS;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_slot = slot_n1;
                end
            end

            // close the gap: move entry idx+1 into slot of idx, prefetch idx+2
            S_SHIFT: begin
                if (more) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = MEM_AW_MAX'(r_slot);
                    o_mem_req.wdata = i_mem_rdata;
                    o_mem_req.raddr = MEM_AW_MAX'(slot_n2);
                    n_slot          = slot_n1;
                    n_idx           = r_idx + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_value   <= n_value;
        r_pos_out <= n_pos_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_value_out    = r_value;
    assign o_position_out = r_pos_out;

endmodule
